[rtl/nfa_pkg.sv]
`default_nettype none
package nfa_pkg;

	localparam int USER_ID_BITS_DEF = 16;
	localparam int SERVER_ID_BITS   = 12;
	localparam int STATUS_BITS      = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_BITS-1:0] RES_DONE      = 2'd0;
	localparam logic [STATUS_BITS-1:0] RES_EXHAUSTED = 2'd1;
	localparam logic [STATUS_BITS-1:0] RES_HOLDS_ID  = 2'd2;
	localparam logic [STATUS_BITS-1:0] RES_NOT_HELD  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic                   clr;          // one step of the map clearing pass
		logic                   accept;       // capture the incoming item
		logic                   search;       // issue next candidate read
		logic                   alloc_commit; // mark found id, result done
		logic                   free_commit;  // clear held id
		logic                   set_res;      // load result code (no grant)
		logic [STATUS_BITS-1:0] code;
		logic                   push;         // move result into output register
	} nfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic uid_zero;
		logic uid_noid;
		logic pool_full;
		logic found;
		logic held;
		logic out_free;
	} nfa_stat_t;

endpackage
`default_nettype wire

[rtl/nfa_ctrl.sv]
`default_nettype none
module nfa_ctrl
	import nfa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire nfa_stat_t stat,
	output nfa_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_FREE_RD,
		S_FREE_CHK,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.accept = 1'b1;
					if (!stat.is_free) begin
						if (stat.pool_full) begin
							cmd.set_res = 1'b1;
							cmd.code    = RES_EXHAUSTED;
							state_d     = S_DONE;
						end else if (!stat.uid_zero) begin
							cmd.set_res = 1'b1;
							cmd.code    = RES_HOLDS_ID;
							state_d     = S_DONE;
						end else begin
							state_d = S_SEARCH;
						end
					end else begin
						if (stat.uid_noid) begin
							cmd.set_res = 1'b1;
							cmd.code    = RES_DONE;
							state_d     = S_DONE;
						end else if (stat.uid_zero) begin
							cmd.set_res = 1'b1;
							cmd.code    = RES_NOT_HELD;
							state_d     = S_DONE;
						end else begin
							state_d = S_FREE_RD;
						end
					end
				end
			end
			S_SEARCH: begin
				// reads are pipelined: one candidate issued, the previous one checked
				if (stat.found) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_DONE;
				end else begin
					cmd.search = 1'b1;
				end
			end
			S_FREE_RD: begin
				state_d = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				cmd.set_res     = 1'b1;
				cmd.code        = stat.held ? RES_DONE : RES_NOT_HELD;
				cmd.free_commit = stat.held;
				state_d         = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = ready_q;

endmodule
`default_nettype wire

[rtl/nfa_datapath.sv]
`default_nettype none
module nfa_datapath
	import nfa_pkg::*;
#(
	parameter int ID_BITS = USER_ID_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire nfa_cmd_t                  cmd,
	output nfa_stat_t                      stat,
	input  wire logic                      in_op,
	input  wire logic [ID_BITS-1:0]        in_uid,
	input  wire logic                      cfg_we,
	input  wire logic [SERVER_ID_BITS-1:0] cfg_wdata,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [STATUS_BITS-1:0]         out_status,
	output logic [ID_BITS-1:0]             out_grant,
	output logic [SERVER_ID_BITS+ID_BITS-1:0] out_full
);

	localparam int                 ID_SPACE = 2 ** ID_BITS;
	localparam logic [ID_BITS-1:0] NO_ID    = {ID_BITS{1'b1}};
	localparam logic [ID_BITS-1:0] TOP_ID   = NO_ID - 1'b1;
	localparam logic [ID_BITS-1:0] FIRST_ID = {{(ID_BITS-1){1'b0}}, 1'b1};

	function automatic logic [ID_BITS-1:0] next_id(input logic [ID_BITS-1:0] c);
		next_id = (c >= TOP_ID) ? FIRST_ID : c + 1'b1;
	endfunction

	logic                      used_mem [ID_SPACE];
	logic                      rd_q;
	logic                      mem_we;
	logic [ID_BITS-1:0]        mem_wa;
	logic                      mem_wd;
	logic [ID_BITS-1:0]        mem_ra;

	logic [ID_BITS-1:0]        clr_q;
	logic [ID_BITS-1:0]        uid_q;
	logic [ID_BITS-1:0]        last_q;
	logic [ID_BITS-1:0]        cand_q;
	logic [ID_BITS-1:0]        chk_q;
	logic                      pend_q;
	logic [ID_BITS:0]          count_q;
	logic [SERVER_ID_BITS-1:0] server_q;
	logic [STATUS_BITS-1:0]    res_status_q;
	logic [ID_BITS-1:0]        res_grant_q;
	logic                      out_valid_q;
	logic [STATUS_BITS-1:0]    out_status_q;
	logic [ID_BITS-1:0]        out_grant_q;
	logic [SERVER_ID_BITS+ID_BITS-1:0] out_full_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = uid_q;
		mem_wd = 1'b0;
		if (cmd.clr) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = (clr_q == '0);  // id 0 belongs to the server
		end else if (cmd.alloc_commit) begin
			mem_we = 1'b1;
			mem_wa = chk_q;
			mem_wd = 1'b1;
		end else if (cmd.free_commit) begin
			mem_we = 1'b1;
			mem_wa = uid_q;
			mem_wd = 1'b0;
		end
		mem_ra = cmd.search ? cand_q : uid_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) used_mem[mem_wa] <= mem_wd;
		rd_q <= used_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			last_q      <= '0;
			count_q     <= (ID_BITS+1)'(2);
			server_q    <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cfg_we) server_q <= cfg_wdata;
			if (cmd.accept) pend_q <= 1'b0;
			else if (cmd.search) pend_q <= 1'b1;
			if (cmd.alloc_commit) begin
				last_q  <= chk_q;
				count_q <= count_q + 1'b1;
			end else if (cmd.free_commit && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			uid_q  <= in_uid;
			cand_q <= next_id(last_q);
		end else if (cmd.search) begin
			cand_q <= next_id(cand_q);
			chk_q  <= cand_q;
		end
		if (cmd.alloc_commit) begin
			res_status_q <= RES_DONE;
			res_grant_q  <= chk_q;
		end else if (cmd.set_res) begin
			res_status_q <= cmd.code;
			res_grant_q  <= '0;
		end
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_grant_q  <= res_grant_q;
			// a nonzero grant only comes from a successful allocate
			out_full_q   <= (res_grant_q != '0) ? {server_q, res_grant_q} : '0;
		end
	end

	always_comb begin
		stat.clr_last  = (clr_q == NO_ID);
		stat.is_free   = (in_op == OP_FREE);
		stat.uid_zero  = (in_uid == '0);
		stat.uid_noid  = (in_uid == NO_ID);
		stat.pool_full = (count_q == {1'b0, NO_ID});
		stat.found     = pend_q && !rd_q;
		stat.held      = rd_q;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_grant  = out_grant_q;
	assign out_full   = out_full_q;

endmodule
`default_nettype wire

[rtl/next_fit_id_allocator.sv]
`default_nettype none
// Next-fit user id allocator. Each input transaction is an allocate (tuser 0) or a free
// (tuser 1) of the id in tdata; each produces exactly one result transaction with a
// status, the granted id and the full id (server id above the user id). After reset the
// used-id map is cleared one entry per cycle, all 2**USER_ID_BITS entries (65536 at the
// default), during which s_tready stays low; the config channel is taken at any time.
// A refused allocate, a free of id 0 or a free of the all-ones id goes from acceptance
// straight to its result; a free of any other id first reads and checks its map bit. An
// allocate steps forward from the last issued id over used ids: the search reads one map bit
// per cycle through the single map port, pipelined so a new candidate is read while the
// previous is checked.
// One item is in work at a time; a result waiting in the output register does not stop
// the next item from being accepted.
module next_fit_id_allocator
	import nfa_pkg::*;
#(
	parameter int USER_ID_BITS = USER_ID_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [SERVER_ID_BITS-1:0] cfg_data,   // server_id
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [((USER_ID_BITS+7)/8)*8-1:0] s_tdata,  // user_id
	input  wire logic                      s_tuser,    // opcode
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// status, granted_id, full_id
	output logic [((STATUS_BITS+SERVER_ID_BITS+2*USER_ID_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int IN_W   = ((USER_ID_BITS+7)/8)*8;
	localparam int OUT_W  = ((STATUS_BITS+SERVER_ID_BITS+2*USER_ID_BITS+7)/8)*8;

	nfa_cmd_t                              cmd;
	nfa_stat_t                             stat;
	logic [STATUS_BITS-1:0]                res_status;
	logic [USER_ID_BITS-1:0]               res_grant;
	logic [SERVER_ID_BITS+USER_ID_BITS-1:0] res_full;
	logic [IN_W-1:0]                       in_word;

	assign cfg_ready = 1'b1;
	assign in_word   = s_tdata;

	nfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nfa_datapath #(
		.ID_BITS (USER_ID_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_tuser),
		.in_uid     (in_word[USER_ID_BITS-1:0]),
		.cfg_we     (cfg_valid),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (res_status),
		.out_grant  (res_grant),
		.out_full   (res_full)
	);

	// padding bits above the packed payload are zero
	assign m_tdata = OUT_W'({res_full, res_grant, res_status});

endmodule
`default_nettype wire

[bench/next_fit_id_allocator_tb.sv]
`default_nettype none
module next_fit_id_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nfa_pkg::*;

	localparam int ID_W      = USER_ID_BITS_DEF;
	localparam int IN_W      = ((ID_W+7)/8)*8;
	localparam int OUT_W     = ((STATUS_BITS+SERVER_ID_BITS+2*ID_W+7)/8)*8;
	localparam int ID_SPACE  = 1 << ID_W;
	localparam logic [ID_W-1:0] NO_ID  = '1;
	localparam logic [ID_W-1:0] TOP_ID = NO_ID - 1'b1;
	localparam logic [16:0] POOL_FULL  = 17'h0FFFF;
	localparam int WDOG_LIMIT = 200000;  // exceeds the clearing pass and the worst wrap search
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT_RESULT = 700;
	localparam int PHASE_ITEMS = 500;

	typedef struct packed {
		logic [STATUS_BITS-1:0]         status;
		logic [ID_W-1:0]                granted;
		logic [SERVER_ID_BITS+ID_W-1:0] full;
	} id_result_t;

	typedef struct packed {
		logic       op;
		logic [15:0] uid;
		logic       typed;   // expected value given in the row
		id_result_t res;
	} id_stim_row_t;

	localparam int DIR_ROWS = 20;
	// directed rows run with server id 0xFFF
	localparam id_stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{OP_ALLOC, 16'h0000, 1'b1, '{RES_DONE,      16'h0001, 28'hFFF0001}},
		'{OP_ALLOC, 16'h0000, 1'b1, '{RES_DONE,      16'h0002, 28'hFFF0002}},
		'{OP_ALLOC, 16'hFFFF, 1'b1, '{RES_HOLDS_ID,  16'h0000, 28'h0000000}},
		'{OP_ALLOC, 16'h0001, 1'b1, '{RES_HOLDS_ID,  16'h0000, 28'h0000000}},
		'{OP_ALLOC, 16'h8000, 1'b1, '{RES_HOLDS_ID,  16'h0000, 28'h0000000}},
		'{OP_FREE,  16'hFFFF, 1'b1, '{RES_DONE,      16'h0000, 28'h0000000}},
		'{OP_FREE,  16'h0000, 1'b1, '{RES_NOT_HELD,  16'h0000, 28'h0000000}},
		'{OP_FREE,  16'h0001, 1'b1, '{RES_DONE,      16'h0000, 28'h0000000}},
		'{OP_FREE,  16'h0001, 1'b1, '{RES_NOT_HELD,  16'h0000, 28'h0000000}},
		'{OP_FREE,  16'hFFFE, 1'b1, '{RES_NOT_HELD,  16'h0000, 28'h0000000}},
		'{OP_ALLOC, 16'h0000, 1'b1, '{RES_DONE,      16'h0003, 28'hFFF0003}},
		'{OP_FREE,  16'h0002, 1'b0, '{RES_DONE,      16'h0000, 28'h0000000}},
		'{OP_ALLOC, 16'h0000, 1'b0, '{RES_DONE,      16'h0000, 28'h0000000}},
		'{OP_FREE,  16'h5555, 1'b1, '{RES_NOT_HELD,  16'h0000, 28'h0000000}},
		'{OP_FREE,  16'hAAAA, 1'b1, '{RES_NOT_HELD,  16'h0000, 28'h0000000}},
		'{OP_FREE,  16'h0003, 1'b0, '{RES_DONE,      16'h0000, 28'h0000000}},
		'{OP_FREE,  16'h0004, 1'b0, '{RES_DONE,      16'h0000, 28'h0000000}},
		'{OP_ALLOC, 16'h0000, 1'b0, '{RES_DONE,      16'h0000, 28'h0000000}},
		'{OP_ALLOC, 16'h7FFF, 1'b1, '{RES_HOLDS_ID,  16'h0000, 28'h0000000}},
		'{OP_FREE,  16'h0005, 1'b0, '{RES_DONE,      16'h0000, 28'h0000000}}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [SERVER_ID_BITS-1:0] cfg_data;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_W-1:0]           s_tdata;   // user_id
	logic                      s_tuser;   // opcode
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_W-1:0]          m_tdata;   // status, granted_id, full_id

	next_fit_id_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// mirror of the allocator state
	bit                        id_used [ID_SPACE];
	logic [ID_W-1:0]           last_id;
	logic [16:0]               held_cnt;
	logic [SERVER_ID_BITS-1:0] srv_id;

	id_result_t      grant_q[$];   // expected results, oldest first
	logic [ID_W-1:0] held_ids[$];  // ids handed out, candidates for frees
	int              err_cnt = 0;
	int              rx_cnt;
	bit              idle_on;

	function automatic id_result_t apply_id_op(logic op, logic [ID_W-1:0] uid);
		id_result_t r;
		logic [ID_W:0] cand;
		int n;
		bit hit;
		r = '0;
		if (op == OP_ALLOC) begin
			if (held_cnt == POOL_FULL) begin
				r.status = RES_EXHAUSTED;
			end else if (uid != '0) begin
				r.status = RES_HOLDS_ID;
			end else begin
				cand = {1'b0, last_id};
				hit = 1'b0;
				for (n = 0; n < ID_SPACE && !hit; n++) begin
					cand = cand + 1'b1;
					if (cand > {1'b0, TOP_ID})
						cand = (ID_W+1)'(1);
					if (!id_used[cand[ID_W-1:0]])
						hit = 1'b1;
				end
				if (!hit) begin
					r.status = RES_EXHAUSTED;
				end else begin
					id_used[cand[ID_W-1:0]] = 1'b1;
					last_id = cand[ID_W-1:0];
					held_cnt = held_cnt + 1'b1;
					r.status = RES_DONE;
					r.granted = cand[ID_W-1:0];
					r.full = {srv_id, cand[ID_W-1:0]};
				end
			end
		end else begin
			if (uid == NO_ID) begin
				r.status = RES_DONE;
			end else if (uid == '0 || !id_used[uid]) begin
				r.status = RES_NOT_HELD;
			end else begin
				id_used[uid] = 1'b0;
				if (held_cnt != '0)
					held_cnt = held_cnt - 1'b1;
				r.status = RES_DONE;
			end
		end
		return r;
	endfunction

	task automatic send_id_op(input logic op, input logic [ID_W-1:0] uid,
			input bit typed, input id_result_t typed_res);
		int gap;
		id_result_t r;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = IN_W'(uid);
		do @(posedge clk); while (!s_tready);
		r = apply_id_op(op, uid);
		if (op == OP_ALLOC && r.status == RES_DONE)
			held_ids.push_back(r.granted);
		grant_q.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_server_id(input logic [SERVER_ID_BITS-1:0] v);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		srv_id = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_random_op();
		int pick;
		int k;
		logic [ID_W-1:0] uid;
		pick = $urandom_range(0, 99);
		// keep the held set bounded so next-fit searches stay short
		if (pick < 45 && held_ids.size() > 400)
			pick = 60;
		if (pick < 45) begin
			send_id_op(OP_ALLOC, '0, 1'b0, '0);
		end else if (pick < 52) begin
			send_id_op(OP_ALLOC, ID_W'($urandom_range(1, ID_SPACE-1)), 1'b0, '0);
		end else if (pick < 80) begin
			if (held_ids.size() == 0) begin
				send_id_op(OP_ALLOC, '0, 1'b0, '0);
			end else begin
				k = $urandom_range(0, held_ids.size()-1);
				uid = held_ids[k];
				held_ids.delete(k);
				send_id_op(OP_FREE, uid, 1'b0, '0);
			end
		end else if (pick < 92) begin
			send_id_op(OP_FREE, ID_W'($urandom_range(0, ID_SPACE-1)), 1'b0, '0);
		end else if (pick < 96) begin
			send_id_op(OP_FREE, NO_ID, 1'b0, '0);
		end else begin
			send_id_op(OP_FREE, '0, 1'b0, '0);
		end
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin : result_sink
		int gap;
		bit hold_done;
		id_result_t got;
		id_result_t want;
		m_tready = 1'b0;
		hold_done = 1'b0;
		rx_cnt = 0;
		forever begin
			gap = idle_on ? $urandom_range(0, 15) : 0;
			if (!hold_done && rx_cnt == HOLD_AT_RESULT) begin
				gap = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.status = m_tdata[1:0];
			got.granted = m_tdata[2 +: ID_W];
			got.full = m_tdata[2+ID_W +: SERVER_ID_BITS+ID_W];
			rx_cnt++;
			if (grant_q.size() == 0) begin
				$error("result transaction with nothing pending: status %0d id %0h",
					got.status, got.granted);
				err_cnt++;
			end else begin
				want = grant_q.pop_front();
				if (got.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					err_cnt++;
				end
				if (got.granted != want.granted) begin
					$error("granted_id: expected %0h, got %0h", want.granted, got.granted);
					err_cnt++;
				end
				if (got.full != want.full) begin
					$error("full_id: expected %0h, got %0h", want.full, got.full);
					err_cnt++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int i;
		int ph;
		int k;
		logic [ID_W-1:0] uid;
		logic [SERVER_ID_BITS-1:0] phase_srv [4];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ALLOC;
		idle_on = 1'b1;
		for (i = 0; i < ID_SPACE; i++)
			id_used[i] = 1'b0;
		id_used[0] = 1'b1;
		last_id = '0;
		held_cnt = 17'd2;
		srv_id = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part; the write lands during the clearing pass
		write_server_id('1);
		for (i = 0; i < DIR_ROWS; i++)
			send_id_op(DIR_TAB[i].op, ID_W'(DIR_TAB[i].uid), DIR_TAB[i].typed, DIR_TAB[i].res);
		wait_drained();

		// random part, a new server id per phase
		phase_srv[0] = '0;
		phase_srv[1] = SERVER_ID_BITS'($urandom);
		phase_srv[2] = 12'h800;
		phase_srv[3] = SERVER_ID_BITS'($urandom);
		for (ph = 0; ph < 4; ph++) begin
			write_server_id(phase_srv[ph]);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 50 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				send_random_op();
			end
			wait_drained();
		end

		// back-to-back allocates with no idle cycles
		idle_on = 1'b0;
		write_server_id(12'h5A5);
		for (k = 0; k < 16; k++)
			send_id_op(OP_ALLOC, '0, 1'b0, '0);
		send_id_op(OP_ALLOC, NO_ID, 1'b0, '0);
		// release a few ids, then allocate again
		for (k = 0; k < 3; k++) begin
			do uid = ID_W'($urandom_range(1, ID_SPACE-2)); while (!id_used[uid]);
			send_id_op(OP_FREE, uid, 1'b0, '0);
		end
		idle_on = 1'b1;
		for (k = 0; k < 4; k++)
			send_id_op(OP_ALLOC, '0, 1'b0, '0);
		send_id_op(OP_FREE, TOP_ID, 1'b0, '0);
		send_id_op(OP_ALLOC, '0, 1'b0, '0);
		wait_drained();

		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/nfa_pkg.sv
rtl/nfa_ctrl.sv
rtl/nfa_datapath.sv
rtl/next_fit_id_allocator.sv
bench/next_fit_id_allocator_tb.sv
